### sv/gvc_pkg.sv
// Shared constants and types for the greedy vertex coloring core.
`timescale 1ns / 1ps
package gvc_pkg;

  localparam int REQ_W   = 1;
  localparam int NODE_W  = 7;
  localparam int COLOR_W = 3;

  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_DEGREE_DEF = 4;

  localparam logic [REQ_W-1:0] REQ_EDGE = 1'b0;
  localparam logic [REQ_W-1:0] REQ_RUN  = 1'b1;

  typedef struct packed {
    logic clr;
    logic acc;
  } color_ctl_t;

endpackage

### sv/gvc_if.sv
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
interface gvc_req_if;
  import gvc_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [NODE_W-1:0] node_count;

  modport source (output valid, req_type, node_a, node_b, node_count, input ready);
  modport sink   (input valid, req_type, node_a, node_b, node_count, output ready);
endinterface

interface gvc_res_if;
  import gvc_pkg::*;
  logic               valid;
  logic               ready;
  logic [NODE_W-1:0]  node_number;
  logic [COLOR_W-1:0] color;
  logic               last;
  logic               overflow;

  modport source (output valid, node_number, color, last, overflow, input ready);
  modport sink   (input valid, node_number, color, last, overflow, output ready);
endinterface

### sv/gvc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### sv/gvc_color_unit.sv
// Used-color mask accumulator and lowest free color search.
`timescale 1ns / 1ps
module gvc_color_unit #(
  parameter int CW = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gvc_pkg::color_ctl_t ctl_i,
  input  logic [CW-1:0]       color_i,
  output logic [CW-1:0]       pick_o
);
  import gvc_pkg::*;

  localparam int NC = 2 ** CW;

  logic [NC-1:0] used_q, used_d;

  always_comb begin
    used_d = used_q;
    if (ctl_i.clr) begin
      used_d = '0;
    end else if (ctl_i.acc) begin
      used_d[color_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_comb begin
    pick_o = '0;
    for (int c = NC - 1; c >= 1; c--) begin
      if (!used_q[c]) begin
        pick_o = CW'(c);
      end
    end
  end
endmodule

### sv/greedy_vertex_coloring_core.sv
// Greedy vertex coloring core: edge loader, run sequencer and result register.
// Edge beat: ready low after acceptance (degree reads, then two slot writes); a full
//   degree drops it after the reads; a zero, too big or self-loop endpoint at once.
// Run beat: per node a degree read, then a table read and a color read per neighbor,
//   and a pick that may wait for the result slot; then a sweep clears degrees/colors.
// Reset: asynchronous, active low; a sweep clearing all MAX_NODES entries runs first.
`timescale 1ns / 1ps
module greedy_vertex_coloring_core #(
  parameter int MAX_NODES  = gvc_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = gvc_pkg::MAX_DEGREE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gvc_req_if.sink       req_i,
  gvc_res_if.source     res_o
);
  import gvc_pkg::*;

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
  localparam int CW        = $clog2(MAX_DEGREE + 2);
  localparam int SW        = DEG_W + CW;
  localparam int TAB_DEPTH = MAX_NODES * MAX_DEGREE;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_E_RDB, S_E_CHK, S_E_WB,
    S_R_RD, S_R_DEG, S_R_NB, S_R_COL, S_R_PICK
  } state_e;

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [IDX_W-1:0] idx,
                                                 input logic [DEG_W-1:0] slot);
    return TAB_AW'(TAB_AW'(idx) * TAB_AW'(MAX_DEGREE)) + TAB_AW'(slot);
  endfunction

  state_e             state_q;
  logic [IDX_W-1:0]   i_q, a_idx_q, b_idx_q;
  logic [CNT_W-1:0]   n_q;
  logic [DEG_W-1:0]   deg_a_q, deg_b_q, deg_i_q, k_q;
  logic               dropped_q;
  logic               res_valid_q;
  logic [NODE_W-1:0]  res_node_q;
  logic [COLOR_W-1:0] res_color_q;
  logic               res_last_q, res_ovf_q;

  logic               st_we, st_re, tab_we, tab_re;
  logic [IDX_W-1:0]   st_waddr, st_raddr;
  logic [SW-1:0]      st_wdata, st_rdata;
  logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
  logic [IDX_W-1:0]   tab_wdata, tab_rdata;
  logic [DEG_W-1:0]   rd_deg;
  logic [CW-1:0]      rd_color, pick;
  color_ctl_t         cu_ctl;

  logic               in_acc, edge_bad, slot_free, last_node, deg_fit, res_load;
  logic [IDX_W-1:0]   in_a_idx, in_b_idx;
  logic [CNT_W-1:0]   run_n;

  assign in_acc    = req_i.valid && req_i.ready;
  assign in_a_idx  = IDX_W'(req_i.node_a - NODE_W'(1));
  assign in_b_idx  = IDX_W'(req_i.node_b - NODE_W'(1));
  assign edge_bad  = (req_i.node_a == '0) || (req_i.node_b == '0) ||
                     (req_i.node_a > MAX_NODES) || (req_i.node_b > MAX_NODES) ||
                     (req_i.node_a == req_i.node_b);
  assign run_n     = (req_i.node_count > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                    : CNT_W'(req_i.node_count);
  assign rd_deg    = st_rdata[SW-1:CW];
  assign rd_color  = st_rdata[CW-1:0];
  assign slot_free = !res_valid_q || res_o.ready;
  assign res_load  = (state_q == S_R_PICK) && slot_free;
  assign last_node = (CNT_W'(i_q) + CNT_W'(1)) == n_q;
  assign deg_fit   = (deg_a_q < MAX_DEGREE) && (rd_deg < MAX_DEGREE);

  gvc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  gvc_ram #(.WIDTH(IDX_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  gvc_color_unit #(.CW(CW)) u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cu_ctl),
    .color_i (rd_color),
    .pick_o  (pick)
  );

  always_comb begin
    st_we     = 1'b0;
    st_waddr  = i_q;
    st_wdata  = '0;
    st_re     = 1'b0;
    st_raddr  = i_q;
    tab_we    = 1'b0;
    tab_waddr = tab_addr(a_idx_q, deg_a_q);
    tab_wdata = b_idx_q;
    tab_re    = 1'b0;
    tab_raddr = tab_addr(i_q, '0);
    cu_ctl    = '0;
    unique case (state_q)
      S_CLEAR: begin
        st_we = 1'b1;
      end
      S_IDLE: begin
        if (in_acc && req_i.req_type == REQ_EDGE) begin
          st_re    = 1'b1;
          st_raddr = in_a_idx;
        end
      end
      S_E_RDB: begin
        st_re    = 1'b1;
        st_raddr = b_idx_q;
      end
      S_E_CHK: begin
        if (deg_fit) begin
          tab_we   = 1'b1;
          st_we    = 1'b1;
          st_waddr = a_idx_q;
          st_wdata = {DEG_W'(deg_a_q + DEG_W'(1)), CW'(0)};
        end
      end
      S_E_WB: begin
        tab_we    = 1'b1;
        tab_waddr = tab_addr(b_idx_q, deg_b_q);
        tab_wdata = a_idx_q;
        st_we     = 1'b1;
        st_waddr  = b_idx_q;
        st_wdata  = {DEG_W'(deg_b_q + DEG_W'(1)), CW'(0)};
      end
      S_R_RD: begin
        st_re      = 1'b1;
        cu_ctl.clr = 1'b1;
      end
      S_R_DEG: begin
        tab_re = (rd_deg != '0);
      end
      S_R_NB: begin
        st_re    = 1'b1;
        st_raddr = tab_rdata;
      end
      S_R_COL: begin
        cu_ctl.acc = 1'b1;
        tab_raddr  = tab_addr(i_q, DEG_W'(k_q + DEG_W'(1)));
        tab_re     = (DEG_W'(k_q + DEG_W'(1)) != deg_i_q);
      end
      S_R_PICK: begin
        if (slot_free) begin
          st_we    = 1'b1;
          st_wdata = {deg_i_q, pick};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      i_q         <= '0;
      a_idx_q     <= '0;
      b_idx_q     <= '0;
      n_q         <= '0;
      deg_a_q     <= '0;
      deg_b_q     <= '0;
      deg_i_q     <= '0;
      k_q         <= '0;
      dropped_q   <= 1'b0;
      res_valid_q <= 1'b0;
      res_node_q  <= '0;
      res_color_q <= '0;
      res_last_q  <= 1'b0;
      res_ovf_q   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (i_q == IDX_W'(MAX_NODES - 1)) begin
            i_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            i_q <= IDX_W'(i_q + IDX_W'(1));
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (req_i.req_type == REQ_RUN) begin
              n_q <= run_n;
              i_q <= '0;
              if (run_n == '0) begin
                dropped_q <= 1'b0;
                state_q   <= S_CLEAR;
              end else begin
                state_q <= S_R_RD;
              end
            end else if (edge_bad) begin
              dropped_q <= 1'b1;
            end else begin
              a_idx_q <= in_a_idx;
              b_idx_q <= in_b_idx;
              state_q <= S_E_RDB;
            end
          end
        end
        S_E_RDB: begin
          deg_a_q <= rd_deg;
          state_q <= S_E_CHK;
        end
        S_E_CHK: begin
          if (deg_fit) begin
            deg_b_q <= rd_deg;
            state_q <= S_E_WB;
          end else begin
            dropped_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        S_E_WB: begin
          state_q <= S_IDLE;
        end
        S_R_RD: begin
          state_q <= S_R_DEG;
        end
        S_R_DEG: begin
          deg_i_q <= rd_deg;
          k_q     <= '0;
          state_q <= (rd_deg == '0) ? S_R_PICK : S_R_NB;
        end
        S_R_NB: begin
          state_q <= S_R_COL;
        end
        S_R_COL: begin
          k_q     <= DEG_W'(k_q + DEG_W'(1));
          state_q <= (DEG_W'(k_q + DEG_W'(1)) == deg_i_q) ? S_R_PICK : S_R_NB;
        end
        S_R_PICK: begin
          if (slot_free) begin
            res_node_q  <= NODE_W'(CNT_W'(i_q) + CNT_W'(1));
            res_color_q <= COLOR_W'(pick);
            res_last_q  <= last_node;
            res_ovf_q   <= dropped_q;
            if (last_node) begin
              i_q       <= '0;
              dropped_q <= 1'b0;
              state_q   <= S_CLEAR;
            end else begin
              i_q     <= IDX_W'(i_q + IDX_W'(1));
              state_q <= S_R_RD;
            end
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = res_valid_q;
  assign res_o.node_number = res_node_q;
  assign res_o.color       = res_color_q;
  assign res_o.last        = res_last_q;
  assign res_o.overflow    = res_ovf_q;
endmodule

### sv/gvc_checker.sv
// Port-level assertions for the coloring core, bound to the top level.
`timescale 1ns / 1ps
module gvc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [gvc_pkg::REQ_W-1:0]  in_req_type_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [gvc_pkg::NODE_W-1:0] out_node_number_i,
  input logic [gvc_pkg::COLOR_W-1:0] out_color_i,
  input logic                       out_last_i
);
  import gvc_pkg::*;

  // a run beat always keeps the core busy on the following cycle
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_req_type_i == REQ_RUN |=> !in_ready_i)
    else $error("core ready right after a run beat");

  // no request is taken while a run still has results to produce
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("request taken in the middle of a run");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_color_i != '0 && out_node_number_i != '0)
    else $error("result with zero color or node number");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_node_number_i) &&
      $stable(out_color_i) && $stable(out_last_i))
    else $error("stalled result beat changed");
endmodule

bind greedy_vertex_coloring_core gvc_checker u_gvc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .in_req_type_i     (req_i.req_type),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .out_node_number_i (res_o.node_number),
  .out_color_i       (res_o.color),
  .out_last_i        (res_o.last)
);
